/* hw/rtl/srem_pkg.sv */
// ============================================================================
// srem_pkg
// Shared types and constants for the stage rate EMA monitor.
// ============================================================================
package srem_pkg;

    localparam int TASK_SLOTS = 256;
    localparam int ADDR_W     = $clog2(TASK_SLOTS);
    localparam int NS_W       = 30;
    localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    typedef struct packed {
        logic [7:0]  task_index;
        logic        in_range;
        logic        entry_ready;
        logic [63:0] prod_count;
        logic [63:0] completed;
        logic [31:0] unflushed_batches;
        logic [63:0] now_time_ns;
    } item_t;

    typedef struct packed {
        logic [63:0] last_produced;
        logic [63:0] last_completed;
        logic [63:0] last_time;
        logic [63:0] produced_ema;
        logic [63:0] completed_ema;
        logic [63:0] flushable_ema;
    } row_t;

    typedef struct packed {
        logic  valid;
        item_t head;
    } queue_head_t;

    localparam row_t RESET_ROW = '{
        last_produced:  64'd0,
        last_completed: ALL_ONES,
        last_time:      64'd0,
        produced_ema:   64'd0,
        completed_ema:  64'd0,
        flushable_ema:  64'd0
    };

    function automatic logic [63:0] ema_step(input logic [63:0] ema,
                                             input logic [63:0] sample);
        logic [63:0] sum;
        sum = sample + (ema << 1) + ema;
        return (ema == 64'd0) ? sample : (sum >> 2);
    endfunction

endpackage

/* hw/rtl/stage_rate_ema_monitor.sv */
// ============================================================================
// stage_rate_ema_monitor
// Per-task produced, completed and flushable rate estimator with EMA smoothing.
// ============================================================================
// When the rates are recomputed, an item passes through a low and a high
// multiply step and 128 divide steps in three parallel dividers; otherwise
// it bypasses the dividers. Items are processed one at a time, and the
// bit-serial dividers bound the throughput: no new item starts until the last is in the output register.
// Reset clears the flush threshold, the task entry valid bits and all control.
// ============================================================================
module stage_rate_ema_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  task_index,
    input  logic        entry_ready,
    input  logic [63:0] prod_count,
    input  logic [63:0] raw_completed_seq,
    input  logic [31:0] unflushed_batches,
    input  logic [63:0] now_time_ns,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  task_id_out,
    output logic [63:0] prod_rate,
    output logic [63:0] comp_rate,
    output logic [63:0] flushable_rate,
    output logic        rates_updated
);
    import srem_pkg::*;

    logic [31:0] flush_level_reg;
    queue_head_t q_head;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_level_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            flush_level_reg <= cfg_wdata;
        end
    end

    srem_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .task_index(task_index), .entry_ready(entry_ready),
        .prod_count(prod_count), .raw_completed_seq(raw_completed_seq),
        .unflushed_batches(unflushed_batches), .now_time_ns(now_time_ns),
        .q_head(q_head), .q_pop(q_pop)
    );

    srem_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_head(q_head), .q_pop(q_pop),
        .flush_level(flush_level_reg),
        .out_valid(out_valid), .out_ready(out_ready), .task_id_out(task_id_out),
        .prod_rate(prod_rate), .comp_rate(comp_rate),
        .flushable_rate(flushable_rate), .rates_updated(rates_updated)
    );

endmodule

/* hw/rtl/srem_front.sv */
// ============================================================================
// srem_front
// Accepts snapshots, maps the raw completion sequence and queues the items.
// ============================================================================
module srem_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  task_index,
    input  logic                        entry_ready,
    input  logic [63:0]                 prod_count,
    input  logic [63:0]                 raw_completed_seq,
    input  logic [31:0]                 unflushed_batches,
    input  logic [63:0]                 now_time_ns,
    output srem_pkg::queue_head_t       q_head,
    input  logic                        q_pop
);
    import srem_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    item_t       item;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && (count_reg != 2'd0);

    always_comb
    begin
        item.task_index        = task_index;
        item.in_range          = ({9'd0, task_index} < 17'(TASK_SLOTS));
        item.entry_ready       = entry_ready;
        item.prod_count        = prod_count;
        item.completed         = (raw_completed_seq == ALL_ONES || raw_completed_seq == 64'd0)
                                 ? raw_completed_seq : raw_completed_seq - 64'd1;
        item.unflushed_batches = unflushed_batches;
        item.now_time_ns       = now_time_ns;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.head  = slot_reg[rd_ptr_reg];

endmodule

/* hw/rtl/srem_div.sv */
// ============================================================================
// srem_div
// Scales a delta by one billion in two partial products, then divides the
// 128-bit product by the elapsed time one quotient bit per cycle.
// ============================================================================
module srem_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] delta,
    input  logic [63:0] dt,
    output logic        done,
    output logic [63:0] quotient
);
    import srem_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MLO  = 2'd1;
    localparam logic [1:0] ST_MHI  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]   state_reg;
    logic [1:0]   state_next;
    logic         done_reg;
    logic         done_next;
    logic [6:0]   cnt_reg;
    logic [6:0]   cnt_next;
    logic [63:0]  delta_reg;
    logic [63:0]  dt_reg;
    logic [127:0] dvd_reg;
    logic [127:0] dvd_next;
    logic [63:0]  rem_reg;
    logic [63:0]  rem_next;
    logic [63:0]  q_reg;
    logic [63:0]  q_next;
    logic [61:0]  prod;
    logic [64:0]  rem_shift;
    logic [31:0]  mul_a;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        mul_a      = (state_reg == ST_MLO) ? delta_reg[31:0] : delta_reg[63:32];
        prod       = {30'd0, mul_a} * {32'd0, NS_PER_SEC};
        rem_shift  = {rem_reg, dvd_reg[127]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MLO;
                    done_next  = 1'b0;
                end
            end
            ST_MLO:
            begin
                dvd_next   = {66'd0, prod};
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                dvd_next   = dvd_reg + {34'd0, prod, 32'd0};
                rem_next   = 64'd0;
                q_next     = 64'd0;
                cnt_next   = 7'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                dvd_next = {dvd_reg[126:0], 1'b0};
                if (rem_shift >= {1'b0, dt_reg})
                begin
                    rem_next = 64'(rem_shift - {1'b0, dt_reg});
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[63:0];
                    q_next   = {q_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            delta_reg <= delta;
            dt_reg    <= dt;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* hw/rtl/srem_back.sv */
// ============================================================================
// srem_back
// Per-task state memory, rate computation sequencer, EMA update and the
// output register.
// ============================================================================
module srem_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  srem_pkg::queue_head_t q_head,
    output logic                  q_pop,
    input  logic [31:0]           flush_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            task_id_out,
    output logic [63:0]           prod_rate,
    output logic [63:0]           comp_rate,
    output logic [63:0]           flushable_rate,
    output logic                  rates_updated
);
    import srem_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    row_t              mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] valid_reg;
    row_t              rd_row_reg;
    logic              hit_reg;
    item_t             cur_reg;
    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              upd_reg;
    logic              out_valid_reg;
    logic [7:0]        task_id_reg;
    logic [63:0]       prate_reg;
    logic [63:0]       crate_reg;
    logic [63:0]       frate_reg;
    logic              rupd_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;
    row_t              row;
    row_t              new_row;
    logic              first;
    logic [63:0]       dt;
    logic [63:0]       dp;
    logic [63:0]       dc;
    logic [63:0]       df;
    logic              div_start;
    logic              do_update;
    logic              out_free;
    logic              finish;
    logic              store;
    logic [63:0]       qp;
    logic [63:0]       qc;
    logic [63:0]       qf;
    logic              dn_p;
    logic              dn_c;
    logic              dn_f;

    assign rd_addr  = ADDR_W'(q_head.head.task_index);
    assign cur_addr = ADDR_W'(cur_reg.task_index);
    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_head.valid;
    assign finish   = (state_reg == S_DONE) && out_free;
    assign store    = finish && cur_reg.in_range && cur_reg.entry_ready;

    always_comb
    begin
        row   = hit_reg ? rd_row_reg : RESET_ROW;
        first = (row.last_produced == 64'd0) && (row.last_completed == ALL_ONES);
        dt    = first ? 64'd0 : cur_reg.now_time_ns - row.last_time;
        dp    = cur_reg.prod_count - row.last_produced;
        if (row.last_completed == ALL_ONES)
        begin
            dc = (cur_reg.completed == ALL_ONES) ? 64'd0 : cur_reg.completed + 64'd1;
        end
        else
        begin
            dc = cur_reg.completed - row.last_completed;
        end
        df = (cur_reg.unflushed_batches > flush_level)
             ? {32'd0, cur_reg.unflushed_batches} : 64'd0;
        do_update = cur_reg.in_range && cur_reg.entry_ready && (dt != 64'd0);
        div_start = (state_reg == S_CALC) && do_update;

        new_row.last_produced  = cur_reg.prod_count;
        new_row.last_completed = cur_reg.completed;
        new_row.last_time      = cur_reg.now_time_ns;
        new_row.produced_ema   = upd_reg ? ema_step(row.produced_ema, qp) : row.produced_ema;
        new_row.completed_ema  = upd_reg ? ema_step(row.completed_ema, qc) : row.completed_ema;
        new_row.flushable_ema  = upd_reg ? ema_step(row.flushable_ema, qf) : row.flushable_ema;

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_head.valid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = do_update ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (dn_p && dn_c && dn_f)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    srem_div u_div_p (.clk(clk), .rst_n(rst_n), .start(div_start), .delta(dp), .dt(dt),
                      .done(dn_p), .quotient(qp));
    srem_div u_div_c (.clk(clk), .rst_n(rst_n), .start(div_start), .delta(dc), .dt(dt),
                      .done(dn_c), .quotient(qc));
    srem_div u_div_f (.clk(clk), .rst_n(rst_n), .start(div_start), .delta(df), .dt(dt),
                      .done(dn_f), .quotient(qf));

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_row_reg <= mem[rd_addr];
            cur_reg    <= q_head.head;
        end
        if (store)
        begin
            mem[cur_addr] <= new_row;
        end
        if (state_reg == S_CALC)
        begin
            upd_reg <= do_update;
        end
        if (finish)
        begin
            task_id_reg <= cur_reg.task_index;
            prate_reg   <= cur_reg.in_range ? new_row.produced_ema : 64'd0;
            crate_reg   <= cur_reg.in_range ? new_row.completed_ema : 64'd0;
            frate_reg   <= cur_reg.in_range ? new_row.flushable_ema : 64'd0;
            rupd_reg    <= upd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
            if (store)
            begin
                valid_reg[cur_addr] <= 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign task_id_out    = task_id_reg;
    assign prod_rate      = prate_reg;
    assign comp_rate      = crate_reg;
    assign flushable_rate = frate_reg;
    assign rates_updated  = rupd_reg;

    a_div_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cur_reg.in_range && cur_reg.entry_ready)
        else $error("Division running for an item that needs no update.");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("Result appeared without a finished item.");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_CALC)
        else $error("Sequencer did not start on a popped item.");

endmodule
